### design/font_cmap_glyph_lookup_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cmap glyph lookup block
// Each macro expands to a labeled concurrent assertion, or to nothing for
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FONT_CMAP_GLYPH_LOOKUP_DEFINES_SVH
`define FONT_CMAP_GLYPH_LOOKUP_DEFINES_SVH
`ifndef SYNTH
`define FCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants of the cmap glyph lookup block.
// ----------------------------------------------------------------------------
package fcm_pkg;
    localparam int unsigned TableBytes = 65536;
    localparam int unsigned AddrW      = $clog2(TableBytes);

    localparam logic [2:0] FMT_0    = 3'd0;
    localparam logic [2:0] FMT_4    = 3'd1;
    localparam logic [2:0] FMT_6    = 3'd2;
    localparam logic [2:0] FMT_12   = 3'd3;

    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_REMAP  = 2'd1;
    localparam logic [1:0] CFG_LENGTH = 2'd2;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] byte_addr;
        logic [7:0]  byte_value;
        logic [20:0] codepoint;
    } t_in_item;

    typedef struct packed {
        logic [15:0] glyph_id;
    } t_out_item;

    // read and write request from sequencer to store
    typedef struct packed {
        logic        rd_en;
        logic [35:0] rd_addr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
    } t_mem_req;
endpackage

### design/fcm_stream_if.sv
// ----------------------------------------------------------------------------
// fcm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fcm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/font_cmap_glyph_lookup.sv
// ----------------------------------------------------------------------------
// font_cmap_glyph_lookup
// OpenType cmap subtable lookup (formats 0, 4, 6, 12) over a loaded byte store.
// ----------------------------------------------------------------------------
// Write transaction: no result. Lookup: each table byte takes an S_FETCH and
// an S_WAIT state of the single store read port; format 4 segments are walked
// in turn and a format 12 search halves its group range per step. Symbol remap
// retries repeat the walk.
// One item at a time: input stalls until the pending result is taken.
// Synchronous active-low reset returns config to format none, remap off,
// length zero; the store contents are undefined until written.
module font_cmap_glyph_lookup
    import fcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcm_stream_if.sink   s_in,
    fcm_stream_if.source m_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data
);
    logic [2:0]  r_format;
    logic        r_remap;
    logic [16:0] r_length;
    logic        r_out_valid;
    logic [15:0] r_out_glyph;
    logic        w_busy, w_done, w_start;
    logic [15:0] w_glyph;
    t_mem_req    w_req;
    logic [7:0]  w_rd;

    // accept only when the sequencer is idle and no result is pending
    assign s_in.ready = !w_busy && !r_out_valid;
    assign w_start    = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= 3'd4;
            r_remap  <= 1'b0;
            r_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_format <= i_cfg_data[2:0];
                CFG_REMAP:  r_remap  <= i_cfg_data[0];
                CFG_LENGTH: r_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) r_out_glyph <= w_glyph;
    end

    assign m_out.valid         = r_out_valid;
    assign m_out.data.glyph_id = r_out_glyph;

    fcm_seq u_seq (
        .i_clk, .i_rst_n,
        .i_format (r_format), .i_remap (r_remap),
        .i_start (w_start), .i_item (s_in.data),
        .o_busy (w_busy), .o_done (w_done), .o_glyph (w_glyph),
        .o_req (w_req), .i_rd_data (w_rd)
    );

    fcm_byte_store u_store (
        .i_clk, .i_table_length (r_length), .i_req (w_req), .o_rd_data (w_rd)
    );
endmodule

### design/fcm_byte_store.sv
// ----------------------------------------------------------------------------
// fcm_byte_store
// Byte memory holding the subtable; reads past length or store return zero.
// ----------------------------------------------------------------------------
module fcm_byte_store
    import fcm_pkg::*;
(
    input  logic        i_clk,
    input  logic [16:0] i_table_length,
    input  t_mem_req    i_req,
    output logic [7:0]  o_rd_data
);
    logic [7:0]  r_mem [TableBytes];
    logic [7:0]  r_raw;
    logic        r_zero;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AddrW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_raw  <= r_mem[i_req.rd_addr[AddrW-1:0]];
            r_zero <= (i_req.rd_addr >= {19'd0, i_table_length})
                      || (i_req.rd_addr >= 36'(TableBytes));
        end
    end

    assign o_rd_data = r_zero ? 8'd0 : r_raw;
endmodule

### design/fcm_seq.sv
// ----------------------------------------------------------------------------
// fcm_seq
// Sequencer: fetches table words a byte at a time and walks the formats.
// ----------------------------------------------------------------------------
module fcm_seq
    import fcm_pkg::*;
`include "font_cmap_glyph_lookup_defines.svh"
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_format,
    input  logic        i_remap,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    output logic        o_done,
    output logic [15:0] o_glyph,
    output t_mem_req    o_req,
    input  logic [7:0]  i_rd_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_MID   = 9'b000010000,
        S_ADDR  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_RETRY = 9'b100000000
    } t_state;

    // step within a format's program
    typedef enum logic [3:0] {
        P_F0, P_F4_SEG, P_F4_END, P_F4_START, P_F4_DELTA, P_F4_RANGE,
        P_F4_GLYPH, P_F6_FIRST, P_F6_COUNT, P_F6_GLYPH, P_F12_N, P_F12_SC,
        P_F12_EC, P_F12_SG
    } t_step;

    t_state      r_state;
    t_step       r_step;
    logic [20:0] r_cp;
    logic        r_retried;
    logic [35:0] r_addr;
    logic [2:0]  r_cnt;
    logic [2:0]  r_len;
    logic [31:0] r_word;
    logic [15:0] r_segx2, r_seg, r_startc, r_delta;
    logic [31:0] r_lo, r_hi, r_mid, r_sc;
    logic [5:0]  r_iter;
    logic [35:0] r_gr;
    logic [15:0] r_glyph;
    logic [31:0] w_word_next;
    logic [35:0] w_gr;

    assign w_word_next = {r_word[23:0], i_rd_data};
    // group record address: 16 + mid * 12
    assign w_gr        = 36'd16 + {1'b0, r_mid, 3'b0} + {2'b0, r_mid, 2'b0};

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_glyph = r_glyph;

    always_comb begin
        o_req         = '0;
        o_req.rd_en   = (r_state == S_FETCH);
        o_req.rd_addr = r_addr + {33'd0, r_cnt};
        o_req.wr_en   = i_start && (i_item.op == OP_WRITE);
        o_req.wr_addr = i_item.byte_addr;
        o_req.wr_data = i_item.byte_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_item.op == OP_LOOKUP) begin
                        r_cp      <= i_item.codepoint;
                        r_retried <= 1'b0;
                        r_glyph   <= '0;
                        r_cnt     <= '0;
                        r_word    <= '0;
                        r_state   <= S_RETRY;
                    end
                end
                S_RETRY: begin
                    // dispatch on format
                    r_cnt  <= '0;
                    r_word <= '0;
                    unique case (i_format)
                        FMT_0: begin
                            if (r_cp >= 21'd256) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F0; r_addr <= 36'd6 + 36'(r_cp);
                                r_len <= 3'd1; r_state <= S_FETCH;
                            end
                        end
                        FMT_4: begin
                            if (r_cp > 21'hFFFF) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F4_SEG; r_addr <= 36'd6;
                                r_len <= 3'd2; r_state <= S_FETCH;
                            end
                        end
                        FMT_6: begin
                            r_step <= P_F6_FIRST; r_addr <= 36'd6;
                            r_len <= 3'd2; r_state <= S_FETCH;
                        end
                        FMT_12: begin
                            r_step <= P_F12_N; r_addr <= 36'd12;
                            r_len <= 3'd4; r_state <= S_FETCH;
                        end
                        default: begin
                            r_glyph <= '0; r_state <= S_DONE;
                        end
                    endcase
                end
                S_FETCH: r_state <= S_WAIT;
                S_WAIT: begin
                    r_word <= w_word_next;
                    if (r_cnt == r_len - 3'd1) begin
                        r_cnt   <= '0;
                        r_state <= S_EVAL;
                    end else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_EVAL: begin
                    r_word <= '0;
                    unique case (r_step)
                        P_F0: begin
                            r_glyph <= {8'd0, r_word[7:0]}; r_state <= S_MUL;
                        end
                        P_F4_SEG: begin
                            r_segx2 <= r_word[15:0]; r_seg <= '0;
                            if (r_word[15:1] == 15'd0) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F4_END; r_addr <= 36'd14;
                                r_state <= S_FETCH;
                            end
                        end
                        P_F4_END: begin
                            if (r_cp[15:0] <= r_word[15:0]) begin
                                r_step <= P_F4_START;
                                r_addr <= 36'd16 + 36'(r_segx2) + {19'd0, r_seg, 1'b0};
                                r_state <= S_FETCH;
                            end else if (r_seg + 16'd1 >= {1'b0, r_segx2[15:1]}) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_seg <= r_seg + 16'd1;
                                r_addr <= 36'd14 + {19'd0, r_seg + 16'd1, 1'b0};
                                r_state <= S_FETCH;
                            end
                        end
                        P_F4_START: begin
                            r_startc <= r_word[15:0];
                            if (r_cp[15:0] < r_word[15:0]) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F4_DELTA;
                                r_addr <= r_addr + 36'(r_segx2);
                                r_state <= S_FETCH;
                            end
                        end
                        P_F4_DELTA: begin
                            r_delta <= r_word[15:0];
                            r_step <= P_F4_RANGE;
                            r_addr <= r_addr + 36'(r_segx2);
                            r_state <= S_FETCH;
                        end
                        P_F4_RANGE: begin
                            if (r_word[15:0] == 16'd0) begin
                                r_glyph <= r_cp[15:0] + r_delta; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F4_GLYPH;
                                r_addr <= r_addr + 36'(r_word[15:0])
                                          + {19'd0, r_cp[15:0] - r_startc, 1'b0};
                                r_state <= S_FETCH;
                            end
                        end
                        P_F4_GLYPH: begin
                            r_glyph <= (r_word[15:0] == 16'd0) ? 16'd0
                                       : r_word[15:0] + r_delta;
                            r_state <= S_MUL;
                        end
                        P_F6_FIRST: begin
                            r_startc <= r_word[15:0]; r_step <= P_F6_COUNT;
                            r_addr <= 36'd8; r_state <= S_FETCH;
                        end
                        P_F6_COUNT: begin
                            if ({1'b0, r_cp} < {6'd0, r_startc}
                                || {1'b0, r_cp} >= {6'd0, r_startc} + {6'd0, r_word[15:0]}) begin
                                r_glyph <= '0; r_state <= S_MUL;
                            end else begin
                                r_step <= P_F6_GLYPH;
                                r_addr <= 36'd10 + {14'd0, r_cp - {5'd0, r_startc}, 1'b0};
                                r_state <= S_FETCH;
                            end
                        end
                        P_F6_GLYPH: begin
                            r_glyph <= r_word[15:0]; r_state <= S_MUL;
                        end
                        P_F12_N: begin
                            r_lo <= '0; r_hi <= r_word; r_iter <= '0;
                            r_state <= S_MID;
                        end
                        P_F12_SC: begin
                            r_sc <= r_word;
                            if ({11'd0, r_cp} < r_word) begin
                                r_hi <= r_mid; r_iter <= r_iter + 6'd1;
                                r_state <= S_MID;
                            end else begin
                                r_step <= P_F12_EC; r_addr <= r_gr + 36'd4;
                                r_state <= S_FETCH;
                            end
                        end
                        P_F12_EC: begin
                            if ({11'd0, r_cp} > r_word) begin
                                r_lo <= r_mid + 32'd1; r_iter <= r_iter + 6'd1;
                                r_state <= S_MID;
                            end else begin
                                r_step <= P_F12_SG; r_addr <= r_gr + 36'd8;
                                r_state <= S_FETCH;
                            end
                        end
                        P_F12_SG: begin
                            r_glyph <= r_word[15:0] + (r_cp[15:0] - r_sc[15:0]);
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_MUL;
                    endcase
                end
                S_MID: begin
                    // one halving step of the group search
                    if (r_iter >= 6'd33 || r_lo >= r_hi) begin
                        r_glyph <= '0; r_state <= S_MUL;
                    end else begin
                        r_mid   <= r_lo + ((r_hi - r_lo) >> 1);
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    // fetch the start code of the middle group
                    r_gr    <= w_gr;
                    r_addr  <= w_gr;
                    r_step  <= P_F12_SC;
                    r_cnt   <= '0;
                    r_len   <= 3'd4;
                    r_state <= S_FETCH;
                end
                S_MUL: begin
                    if (r_glyph == 16'd0 && i_remap && !r_retried
                        && r_cp <= 21'hFF) begin
                        r_retried <= 1'b1;
                        r_cp      <= 21'hF000 + r_cp;
                        r_state   <= S_RETRY;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FCM_ASSERT_NEXT(a_done_one, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE)
    `FCM_ASSERT_IMPL(a_len_ok, i_clk, i_rst_n, r_state == S_FETCH,
        r_len == 3'd1 || r_len == 3'd2 || r_len == 3'd4)
    `FCM_ASSERT_NEXT(a_start_idle, i_clk, i_rst_n, i_start && r_state != S_IDLE, 1'b0)
endmodule
